FILE: design/lps_pkg.sv
// Shared types and constants of the latency path selector.
// Holds the table entry record, the command codes, the register indexes and the
// controller-to-datapath interface structs. Depends on nothing.
package lps_pkg;

  localparam int IDX_W      = 4;
  localparam int RTT_W      = 24;
  localparam int FAIL_W     = 8;
  localparam int SECS_W     = 16;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int Q_W        = 9;
  localparam int LIMIT_W    = RTT_W + Q_W;

  localparam logic [Q_W-1:0]    Q_ONE    = 9'd256;
  localparam logic [FAIL_W-1:0] FAIL_SAT = 8'd255;
  localparam logic [SECS_W-1:0] SECS_SAT = 16'hFFFF;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PROBE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RECORD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SELECT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 3'd4;

  typedef struct packed {
    logic [RTT_W-1:0]  rtt;
    logic              seen;
    logic              reach;
    logic [FAIL_W-1:0] fails;
  } entry_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_DISPATCH,
    DP_APPLY,
    DP_EVAL_START,
    DP_SCAN,
    DP_DECIDE,
    DP_TAIL_A,
    DP_TAIL_C,
    DP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic   latch;
    dp_op_e op;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             tgt_ok;
    logic             eval_go;
    logic             scan_done;
  } status_t;

endpackage

FILE: design/lps_datapath.sv
// Datapath of the latency path selector: configuration registers, server table,
// smoothing and margin arithmetic, evaluate scan and result registers.
// Depends on lps_pkg; driven by lps_ctrl through ctrl_t and status_t.
module lps_datapath #(
  parameter int MAX_SERVERS = 16,
  parameter int FAIL_LIMIT  = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lps_pkg::ctrl_t                   ctrl_i,
  output lps_pkg::status_t                 status_o,
  input  logic [lps_pkg::CMD_W-1:0]        cmd_i,
  input  logic [lps_pkg::IDX_W-1:0]        entry_index_i,
  input  logic                             probe_ok_i,
  input  logic [lps_pkg::RTT_W-1:0]        rtt_sample_i,
  input  logic                             cfg_valid_i,
  input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             done_o,
  output logic [lps_pkg::IDX_W-1:0]        current_index_o,
  output logic [lps_pkg::RTT_W-1:0]        current_rtt_o,
  output logic                             switched_o,
  output logic [lps_pkg::RTT_W-1:0]        entry_rtt_o,
  output logic                             entry_reachable_o,
  output logic [lps_pkg::FAIL_W-1:0]       entry_failures_o,
  output logic                             entry_has_sample_o
);
  import lps_pkg::*;

  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam int CW = (NW > 5) ? NW : 5;

  // Configuration registers.
  logic [4:0]        srv_cnt_q;
  logic [Q_W-1:0]    weight_q;
  logic [RTT_W-1:0]  thr_q;
  logic [Q_W-1:0]    margin_q;
  logic [SECS_W-1:0] cool_q;

  // Latched command.
  logic [CMD_W-1:0] cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic             ok_q;
  logic [RTT_W-1:0] sample_q;

  // Selector state.
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic              ever_q, ever_d;
  logic [SECS_W-1:0] secs_q, secs_d;
  logic              sw_q, sw_d;
  logic              done_q, done_d;

  // Evaluate scan.
  logic [CW-1:0]      sc_q, sc_d;
  logic [CW-1:0]      best_q, best_d;
  logic [RTT_W-1:0]   lead_rtt_q, lead_rtt_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic               rep_ok_q, rep_ok_d;
  logic               cur_ok_q, cur_ok_d;

  // Results.
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic [RTT_W-1:0] res_rtt_q, res_rtt_d;
  logic             res_sw_q, res_sw_d;
  entry_t           res_ent_q, res_ent_d;

  // Server table with one valid bit per entry.
  entry_t                 mem_q [MAX_SERVERS];
  entry_t                 rdata_q;
  logic                   rvld_q;
  logic [MAX_SERVERS-1:0] vld_q;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic                   we;
  logic                   vld_clr;
  entry_t                 rd_ent;
  entry_t                 nxt_ent;

  logic [CW-1:0]     cnt_ext;
  logic [CW-1:0]     n_use;
  logic              idx_in;
  logic              cur_in;
  logic [IDX_W-1:0]  tgt_idx;
  logic [IDX_W-1:0]  rep_idx;
  logic [Q_W-1:0]    w_eff;
  logic [Q_W-1:0]    m_eff;
  logic [Q_W-1:0]    keep_fac;
  logic signed [RTT_W:0]       diff;
  logic signed [Q_W:0]         w_s;
  logic signed [RTT_W+Q_W+1:0] prod;
  logic signed [RTT_W+Q_W+1:0] prod_sh;
  logic [FAIL_W-1:0] fails_inc;
  logic [CW-1:0]     sc_prev;
  logic              cand_hit;

  assign cnt_ext = CW'(srv_cnt_q);
  assign n_use   = (cnt_ext > CW'(MAX_SERVERS)) ? CW'(MAX_SERVERS) : cnt_ext;
  assign idx_in  = CW'(idx_q) < n_use;
  assign cur_in  = CW'(cur_q) < n_use;
  assign tgt_idx = (cmd_q == CMD_PROBE) ? idx_q : cur_q;
  assign rep_idx = (cmd_q == CMD_PROBE || cmd_q == CMD_SELECT) ? idx_q : cur_q;
  assign rd_ent  = rvld_q ? rdata_q : '0;
  assign waddr   = AW'(tgt_idx);

  // Smoothing as old + round(w * (sample - old) / 256), one signed multiply.
  assign w_eff   = (weight_q > Q_ONE) ? Q_ONE : weight_q;
  assign m_eff   = (margin_q > Q_ONE) ? Q_ONE : margin_q;
  assign keep_fac = Q_ONE - m_eff;
  assign diff    = $signed({1'b0, sample_q}) - $signed({1'b0, rd_ent.rtt});
  assign w_s     = $signed({1'b0, w_eff});
  assign prod    = diff * w_s;
  assign prod_sh = (prod + (RTT_W+Q_W+2)'(128)) >>> 8;

  assign fails_inc = (rd_ent.fails == FAIL_SAT) ? FAIL_SAT : rd_ent.fails + 1'b1;

  always_comb begin
    nxt_ent = rd_ent;
    if (cmd_q == CMD_RECORD || ok_q) begin
      nxt_ent.rtt   = rd_ent.seen ? rd_ent.rtt + prod_sh[RTT_W-1:0] : sample_q;
      nxt_ent.seen  = 1'b1;
      nxt_ent.reach = 1'b1;
      nxt_ent.fails = '0;
    end else begin
      nxt_ent.fails = fails_inc;
      if (fails_inc >= FAIL_W'(FAIL_LIMIT)) begin
        nxt_ent.reach = 1'b0;
      end
    end
  end

  // The entry returned in a scan cycle belongs to the index read in the cycle before.
  assign sc_prev  = sc_q - 1'b1;
  assign cand_hit = (sc_prev != CW'(cur_q)) && rd_ent.reach && rd_ent.seen &&
                    (LIMIT_W'({rd_ent.rtt, 8'd0}) < limit_q) && (rd_ent.rtt < lead_rtt_q);

  always_comb begin
    cur_d      = cur_q;
    ever_d     = ever_q;
    secs_d     = secs_q;
    sw_d       = sw_q;
    done_d     = 1'b0;
    sc_d       = sc_q;
    best_d     = best_q;
    lead_rtt_d = lead_rtt_q;
    limit_d    = limit_q;
    rep_ok_d   = rep_ok_q;
    cur_ok_d   = cur_ok_q;
    res_idx_d  = res_idx_q;
    res_rtt_d  = res_rtt_q;
    res_sw_d   = res_sw_q;
    res_ent_d  = res_ent_q;
    raddr      = AW'(tgt_idx);
    we         = 1'b0;
    vld_clr    = 1'b0;
    case (ctrl_i.op)
      DP_DISPATCH: begin
        sw_d   = 1'b0;
        best_d = CW'(cur_q);
        case (cmd_q)
          CMD_TICK: begin
            if (secs_q != SECS_SAT) begin
              secs_d = secs_q + 1'b1;
            end
          end
          CMD_SELECT: begin
            if (idx_in) begin
              cur_d = idx_q;
            end
          end
          CMD_CLEAR: begin
            vld_clr = 1'b1;
            cur_d   = '0;
          end
          default: ;
        endcase
      end
      DP_APPLY: begin
        we = 1'b1;
      end
      DP_EVAL_START: begin
        lead_rtt_d = rd_ent.rtt;
        limit_d    = LIMIT_W'(rd_ent.rtt) * LIMIT_W'(keep_fac);
        raddr      = '0;
        sc_d       = CW'(1);
      end
      DP_SCAN: begin
        raddr = AW'(sc_q);
        sc_d  = sc_q + 1'b1;
        if (cand_hit) begin
          best_d     = sc_prev;
          lead_rtt_d = rd_ent.rtt;
        end
      end
      DP_DECIDE: begin
        if (best_q != CW'(cur_q) && (!ever_q || secs_q >= cool_q)) begin
          cur_d  = IDX_W'(best_q);
          ever_d = 1'b1;
          secs_d = '0;
          sw_d   = 1'b1;
        end
      end
      DP_TAIL_A: begin
        raddr    = AW'(rep_idx);
        rep_ok_d = CW'(rep_idx) < n_use;
      end
      DP_TAIL_C: begin
        res_ent_d = rep_ok_q ? rd_ent : '0;
        raddr     = AW'(cur_q);
        cur_ok_d  = cur_in;
      end
      DP_FINISH: begin
        res_rtt_d = cur_ok_q ? rd_ent.rtt : '0;
        res_idx_d = cur_q;
        res_sw_d  = sw_q;
        done_d    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_cnt_q <= '0;
      weight_q  <= 9'd77;
      thr_q     <= 24'd100000;
      margin_q  <= 9'd51;
      cool_q    <= 16'd30;
      cur_q     <= '0;
      ever_q    <= 1'b0;
      secs_q    <= '0;
      sw_q      <= 1'b0;
      done_q    <= 1'b0;
      sc_q      <= '0;
      vld_q     <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SERVER_COUNT: srv_cnt_q <= cfg_data_i[4:0];
          CFG_WEIGHT:       weight_q  <= cfg_data_i[Q_W-1:0];
          CFG_THRESHOLD:    thr_q     <= cfg_data_i[RTT_W-1:0];
          CFG_MARGIN:       margin_q  <= cfg_data_i[Q_W-1:0];
          CFG_COOLDOWN:     cool_q    <= cfg_data_i[SECS_W-1:0];
          default: ;
        endcase
      end
      cur_q  <= cur_d;
      ever_q <= ever_d;
      secs_q <= secs_d;
      sw_q   <= sw_d;
      done_q <= done_d;
      sc_q   <= sc_d;
      rvld_q <= vld_q[raddr];
      if (vld_clr) begin
        vld_q <= '0;
      end else if (we) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q    <= cmd_i;
      idx_q    <= entry_index_i;
      ok_q     <= probe_ok_i;
      sample_q <= rtt_sample_i;
    end
    best_q     <= best_d;
    lead_rtt_q <= lead_rtt_d;
    limit_q    <= limit_d;
    rep_ok_q   <= rep_ok_d;
    cur_ok_q   <= cur_ok_d;
    res_idx_q  <= res_idx_d;
    res_rtt_q  <= res_rtt_d;
    res_sw_q   <= res_sw_d;
    res_ent_q  <= res_ent_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= nxt_ent;
    end
    rdata_q <= mem_q[raddr];
  end

  assign status_o.cmd       = cmd_q;
  assign status_o.tgt_ok    = (cmd_q == CMD_PROBE) ? idx_in : cur_in;
  assign status_o.eval_go   = rd_ent.seen && (rd_ent.rtt > thr_q);
  assign status_o.scan_done = (sc_q == n_use);

  assign done_o             = done_q;
  assign current_index_o    = res_idx_q;
  assign current_rtt_o      = res_rtt_q;
  assign switched_o         = res_sw_q;
  assign entry_rtt_o        = res_ent_q.rtt;
  assign entry_reachable_o  = res_ent_q.reach;
  assign entry_failures_o   = res_ent_q.fails;
  assign entry_has_sample_o = res_ent_q.seen;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_apply_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == DP_APPLY) |-> status_o.tgt_ok)
    else $error("table write outside the entries in use");

  a_cur_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cur_q) |-> ($past(ctrl_i.op) == DP_DISPATCH || $past(ctrl_i.op) == DP_DECIDE))
    else $error("current entry changed outside select, clear or evaluate");

  a_switch_on_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_sw_q) |-> (cmd_q == CMD_EVAL))
    else $error("switch reported for a command other than evaluate");

endmodule

FILE: design/lps_ctrl.sv
// Controller of the latency path selector: sequences each command through the
// datapath steps. Depends on lps_pkg; drives lps_datapath through ctrl_t.
module lps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output lps_pkg::ctrl_t   ctrl_o,
  input  lps_pkg::status_t status_i
);
  import lps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_APPLY,
    ST_EVAL_START,
    ST_SCAN,
    ST_DECIDE,
    ST_TAIL_A,
    ST_TAIL_C,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  dp_op_e op_q, op_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.cmd)
          CMD_PROBE, CMD_RECORD: state_d = status_i.tgt_ok ? ST_APPLY : ST_TAIL_A;
          CMD_EVAL:              state_d = status_i.tgt_ok ? ST_EVAL_START : ST_TAIL_A;
          default:               state_d = ST_TAIL_A;
        endcase
      end
      ST_APPLY:      state_d = ST_TAIL_A;
      ST_EVAL_START: state_d = status_i.eval_go ? ST_SCAN : ST_DECIDE;
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE:     state_d = ST_TAIL_A;
      ST_TAIL_A:     state_d = ST_TAIL_C;
      ST_TAIL_C:     state_d = ST_FINISH;
      ST_FINISH:     state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_d)
      ST_DISPATCH:   op_d = DP_DISPATCH;
      ST_APPLY:      op_d = DP_APPLY;
      ST_EVAL_START: op_d = DP_EVAL_START;
      ST_SCAN:       op_d = DP_SCAN;
      ST_DECIDE:     op_d = DP_DECIDE;
      ST_TAIL_A:     op_d = DP_TAIL_A;
      ST_TAIL_C:     op_d = DP_TAIL_C;
      ST_FINISH:     op_d = DP_FINISH;
      default:       op_d = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= DP_IDLE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign ctrl_o.latch = accept;
  assign ctrl_o.op    = op_q;

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (op_q == DP_DISPATCH))
    else $error("accepted command not dispatched");

  a_scan_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == DP_SCAN) |-> ($past(op_q) == DP_EVAL_START || $past(op_q) == DP_SCAN))
    else $error("scan entered without evaluate start");

endmodule

FILE: design/latency_path_selector_core.sv
// Top level of the latency path selector: controller plus datapath.
// Depends on lps_pkg, lps_ctrl and lps_datapath.
//
// A command is taken at a rising edge where start_i is high and busy_o is low;
// busy_o then stays high until the command is finished. Each command produces
// exactly one result beat, shown on the result ports for a single cycle with
// done_o high. The receiver cannot stall the block, so the result must be
// captured in that cycle; the result ports are only meaningful while done_o is
// high, and the entry ports may already change in the cycle before each beat.
// A new command may be started in the very cycle that done_o is high.
// The server table has one read port with registered data, and every command
// walks through it one access per cycle. A probe or record for an entry in
// use passes an apply step that writes the entry; second tick, select, clear,
// unknown codes and probes or records that address no entry in use go
// straight to the tail steps. An evaluate scans every entry in use when the
// current server has a sample above the threshold, skips the scan otherwise,
// and goes straight to the tail steps when the current entry lies outside
// the table. The evaluate scan reads one entry per cycle and compares it with
// the best candidate so far, ties among candidates going to the lower index
// and a tie with the current server keeping the current server. Configuration
// writes are always accepted (cfg_ready_o is tied high) and should only be
// issued while the block is idle. After reset the table reads as empty at
// once: a valid bit per entry is cleared by reset and by the clear command,
// so there is no clearing pass.
module latency_path_selector_core #(
  parameter int MAX_SERVERS = 16,
  parameter int FAIL_LIMIT  = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [lps_pkg::CMD_W-1:0]        cmd_i,
  input  logic [lps_pkg::IDX_W-1:0]        entry_index_i,
  input  logic                             probe_ok_i,
  input  logic [lps_pkg::RTT_W-1:0]        rtt_sample_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             done_o,
  output logic [lps_pkg::IDX_W-1:0]        current_index_o,
  output logic [lps_pkg::RTT_W-1:0]        current_rtt_o,
  output logic                             switched_o,
  output logic [lps_pkg::RTT_W-1:0]        entry_rtt_o,
  output logic                             entry_reachable_o,
  output logic [lps_pkg::FAIL_W-1:0]       entry_failures_o,
  output logic                             entry_has_sample_o
);
  import lps_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Register writes never wait.
  assign cfg_ready_o = 1'b1;

  lps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .ctrl_o   (ctrl),
    .status_i (status)
  );

  lps_datapath #(
    .MAX_SERVERS (MAX_SERVERS),
    .FAIL_LIMIT  (FAIL_LIMIT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .status_o           (status),
    .cmd_i              (cmd_i),
    .entry_index_i      (entry_index_i),
    .probe_ok_i         (probe_ok_i),
    .rtt_sample_i       (rtt_sample_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .current_index_o    (current_index_o),
    .current_rtt_o      (current_rtt_o),
    .switched_o         (switched_o),
    .entry_rtt_o        (entry_rtt_o),
    .entry_reachable_o  (entry_reachable_o),
    .entry_failures_o   (entry_failures_o),
    .entry_has_sample_o (entry_has_sample_o)
  );

endmodule
